// ----- rtl/core/sfq_pkg.sv -----
// Package for the sensor fault qualifier: field widths, register map and shared types.
// Used by every module in rtl/core; depends on nothing else.
package sfq_pkg;

  localparam int unsigned ReadingW  = 12;
  localparam int unsigned IndexW    = 8;
  localparam int unsigned CountW    = 5;
  localparam int unsigned ChangeW   = 4;
  localparam int unsigned AddrW     = 4;
  localparam int unsigned DataW     = 32;

  localparam logic [ReadingW-1:0] OpenThresholdRst  = 12'd4000;
  localparam logic [ReadingW-1:0] ShortThresholdRst = 12'd40;
  localparam logic [CountW-1:0]   ConfirmCountRst   = 5'd20;
  localparam logic [ChangeW-1:0]  ChangeLimitRst    = 4'd9;

  typedef enum logic [1:0] {
    REG_OPEN_THRESHOLD  = 2'd0,
    REG_SHORT_THRESHOLD = 2'd1,
    REG_CONFIRM_COUNT   = 2'd2,
    REG_CHANGE_LIMIT    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [ReadingW-1:0] open_threshold;
    logic [ReadingW-1:0] short_threshold;
    logic [CountW-1:0]   confirm_count;
    logic [ChangeW-1:0]  change_limit;
  } cfg_t;

endpackage

// ----- rtl/core/sfq_cfg_regs.sv -----
// Configuration register file of the sensor fault qualifier, written over an APB-style port.
// Depends on sfq_pkg for the register map and the cfg_t bundle.
module sfq_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfq_pkg::AddrW-1:0]   paddr,
  input  logic [sfq_pkg::DataW-1:0]   pwdata,
  output logic [sfq_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output sfq_pkg::cfg_t               cfg
);

  sfq_pkg::cfg_t    cfg_r;
  sfq_pkg::reg_idx_t reg_sel;
  logic             wr_en;

  assign reg_sel = sfq_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_threshold  <= sfq_pkg::OpenThresholdRst;
      cfg_r.short_threshold <= sfq_pkg::ShortThresholdRst;
      cfg_r.confirm_count   <= sfq_pkg::ConfirmCountRst;
      cfg_r.change_limit    <= sfq_pkg::ChangeLimitRst;
    end else if (wr_en) begin
      case (reg_sel)
        sfq_pkg::REG_OPEN_THRESHOLD: begin
          cfg_r.open_threshold <= pwdata[sfq_pkg::ReadingW-1:0];
        end
        sfq_pkg::REG_SHORT_THRESHOLD: begin
          cfg_r.short_threshold <= pwdata[sfq_pkg::ReadingW-1:0];
        end
        sfq_pkg::REG_CONFIRM_COUNT: begin
          cfg_r.confirm_count <= pwdata[sfq_pkg::CountW-1:0];
        end
        sfq_pkg::REG_CHANGE_LIMIT: begin
          cfg_r.change_limit <= pwdata[sfq_pkg::ChangeW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      sfq_pkg::REG_OPEN_THRESHOLD: begin
        prdata = {{(sfq_pkg::DataW-sfq_pkg::ReadingW){1'b0}}, cfg_r.open_threshold};
      end
      sfq_pkg::REG_SHORT_THRESHOLD: begin
        prdata = {{(sfq_pkg::DataW-sfq_pkg::ReadingW){1'b0}}, cfg_r.short_threshold};
      end
      sfq_pkg::REG_CONFIRM_COUNT: begin
        prdata = {{(sfq_pkg::DataW-sfq_pkg::CountW){1'b0}}, cfg_r.confirm_count};
      end
      sfq_pkg::REG_CHANGE_LIMIT: begin
        prdata = {{(sfq_pkg::DataW-sfq_pkg::ChangeW){1'b0}}, cfg_r.change_limit};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

// ----- rtl/core/sfq_debounce.sv -----
// Fault debouncer: a confirm/release counter and a fault flag for one fault condition.
// Depends on sfq_pkg for the counter width.
module sfq_debounce (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic                        abnormal,
  input  logic [sfq_pkg::CountW-1:0]  confirm_count,
  output logic                        flag_nxt
);

  logic [sfq_pkg::CountW-1:0] cnt_r;
  logic [sfq_pkg::CountW-1:0] cnt_nxt;
  logic                       flag_r;

  always_comb begin
    cnt_nxt  = cnt_r;
    flag_nxt = flag_r;
    if (abnormal) begin
      if (cnt_r < confirm_count) begin
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        flag_nxt = 1'b1;
      end
    end else if (flag_r) begin
      if (cnt_r <= sfq_pkg::CountW'(1)) begin
        cnt_nxt  = '0;
        flag_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end else begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      flag_r <= 1'b0;
    end else if (advance) begin
      cnt_r  <= cnt_nxt;
      flag_r <= flag_nxt;
    end
  end

endmodule

// ----- rtl/core/sfq_index_hold.sv -----
// Index change filter: holds the temp index until the input differs from it long enough.
// Depends on sfq_pkg for the index and change counter widths.
module sfq_index_hold (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic [sfq_pkg::IndexW-1:0]  temp_index,
  input  logic [sfq_pkg::ChangeW-1:0] change_limit,
  output logic [sfq_pkg::IndexW-1:0]  held_nxt
);

  logic [sfq_pkg::IndexW-1:0]  held_r;
  logic [sfq_pkg::ChangeW-1:0] change_r;
  logic [sfq_pkg::ChangeW-1:0] change_nxt;
  logic [sfq_pkg::ChangeW:0]   change_inc;

  assign change_inc = {1'b0, change_r} + 1'b1;

  always_comb begin
    held_nxt   = held_r;
    change_nxt = '0;
    if (temp_index != held_r) begin
      if (change_inc > {1'b0, change_limit}) begin
        held_nxt = temp_index;
      end else begin
        change_nxt = change_inc[sfq_pkg::ChangeW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= '0;
      change_r <= '0;
    end else if (advance) begin
      held_r   <= held_nxt;
      change_r <= change_nxt;
    end
  end

endmodule

// ----- rtl/core/sensor_fault_qualifier_top.sv -----
// Top level of the sensor fault qualifier: input register, fault debouncers, index filter,
// result register and configuration port. Depends on sfq_pkg and all rtl/core modules.
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_stall    in_raw_reading, in_temp_index
//   out_     output     out_valid/out_stall  out_open_fault, out_short_fault, out_stable_index
//   cfg      input      psel/penable/pready  paddr, pwdata, prdata
//
// One beat per cycle sustained while out_stall is low; each beat is held in the input register,
// then the result register offers it; it leaves at the following edge at the earliest.
// The input register and the result register each hold one beat, so a new beat is taken
// while a finished result waits; in_stall rises only when both are full and out_stall is high.
// Reset (rst_n low, synchronous) empties both registers and clears counters, flags and the
// held index; the configuration registers return to their defaults.
module sensor_fault_qualifier_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sfq_pkg::ReadingW-1:0]  in_raw_reading,
  input  logic [sfq_pkg::IndexW-1:0]    in_temp_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_open_fault,
  output logic                          out_short_fault,
  output logic [sfq_pkg::IndexW-1:0]    out_stable_index,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfq_pkg::AddrW-1:0]     paddr,
  input  logic [sfq_pkg::DataW-1:0]     pwdata,
  output logic [sfq_pkg::DataW-1:0]     prdata,
  output logic                          pready
);

  sfq_pkg::cfg_t cfg;

  logic                         s1_valid_r;
  logic [sfq_pkg::ReadingW-1:0] s1_reading_r;
  logic [sfq_pkg::IndexW-1:0]   s1_index_r;
  logic                         s1_stall;
  logic                         s1_advance;
  logic                         in_take;

  logic                         open_nxt;
  logic                         short_nxt;
  logic [sfq_pkg::IndexW-1:0]   held_nxt;

  logic                         out_valid_r;
  logic                         out_open_r;
  logic                         out_short_r;
  logic [sfq_pkg::IndexW-1:0]   out_index_r;

  sfq_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign s1_stall   = out_valid_r && out_stall;
  assign s1_advance = s1_valid_r && !s1_stall;
  assign in_stall   = s1_valid_r && s1_stall;
  assign in_take    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_reading_r <= in_raw_reading;
      s1_index_r   <= in_temp_index;
    end
  end

  sfq_debounce u_open (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (s1_advance),
    .abnormal      (s1_reading_r > cfg.open_threshold),
    .confirm_count (cfg.confirm_count),
    .flag_nxt      (open_nxt)
  );

  sfq_debounce u_short (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (s1_advance),
    .abnormal      (s1_reading_r < cfg.short_threshold),
    .confirm_count (cfg.confirm_count),
    .flag_nxt      (short_nxt)
  );

  sfq_index_hold u_index (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (s1_advance),
    .temp_index   (s1_index_r),
    .change_limit (cfg.change_limit),
    .held_nxt     (held_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_open_r  <= open_nxt;
      out_short_r <= short_nxt;
      out_index_r <= held_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_open_fault   = out_open_r;
  assign out_short_fault  = out_short_r;
  assign out_stable_index = out_index_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("Input stalled while a pipeline register was free.");

  a_advance_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_advance |=> out_valid_r)
    else $error("Advanced beat did not reach the result register.");

  a_result_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !s1_advance) |=> !out_valid_r)
    else $error("Delivered result was not removed.");

  a_no_beat_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_stall) |=> s1_valid_r)
    else $error("Held input beat was dropped while stalled.");

endmodule

// ----- bench/tb_sensor_fault_qualifier_top.sv -----
// Testbench for sensor_fault_qualifier_top: directed table and random phases, each result
// checked against a cycle-free predictor of the fault debouncers and the index hold filter,
// or a typed value in directed rows. Depends on sfq_pkg and the RTL under rtl/core.
module tb_sensor_fault_qualifier_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 100000;
  localparam int PhaseCount = 12;
  localparam int PhaseBeats = 128;

  typedef struct packed {
    logic                       open_f;
    logic                       short_f;
    logic [sfq_pkg::IndexW-1:0] idx;
  } fault_result_t;

  typedef struct {
    logic                         is_cfg;
    sfq_pkg::reg_idx_t            reg_sel;
    logic [sfq_pkg::DataW-1:0]    wdata;
    logic [sfq_pkg::ReadingW-1:0] reading;
    logic [sfq_pkg::IndexW-1:0]   index;
    logic                         chk;
    fault_result_t                typed;
  } stim_row_t;

  typedef enum int {RUN_OPEN, RUN_SHORT, RUN_NORMAL, RUN_NOISE} run_kind_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [sfq_pkg::ReadingW-1:0] in_raw_reading;
  logic [sfq_pkg::IndexW-1:0]   in_temp_index;
  logic                         out_valid;
  logic                         out_stall;
  logic                         out_open_fault;
  logic                         out_short_fault;
  logic [sfq_pkg::IndexW-1:0]   out_stable_index;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [sfq_pkg::AddrW-1:0]    paddr;
  logic [sfq_pkg::DataW-1:0]    pwdata;
  logic [sfq_pkg::DataW-1:0]    prdata;
  logic                         pready;

  sensor_fault_qualifier_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_raw_reading   (in_raw_reading),
    .in_temp_index    (in_temp_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_open_fault   (out_open_fault),
    .out_short_fault  (out_short_fault),
    .out_stable_index (out_stable_index),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  logic [sfq_pkg::ReadingW-1:0] thr_open  = sfq_pkg::OpenThresholdRst;
  logic [sfq_pkg::ReadingW-1:0] thr_short = sfq_pkg::ShortThresholdRst;
  logic [sfq_pkg::CountW-1:0]   confirm_n = sfq_pkg::ConfirmCountRst;
  logic [sfq_pkg::ChangeW-1:0]  chg_limit = sfq_pkg::ChangeLimitRst;

  logic [sfq_pkg::CountW-1:0]   open_cnt  = '0;
  logic [sfq_pkg::CountW-1:0]   short_cnt = '0;
  logic                         open_flg  = 1'b0;
  logic                         short_flg = 1'b0;
  logic [sfq_pkg::IndexW-1:0]   held_idx  = '0;
  logic [sfq_pkg::ChangeW-1:0]  chg_cnt   = '0;

  fault_result_t pending_results[$];
  stim_row_t     directed_rows[$];
  int            error_count = 0;
  int            cycle_count = 0;
  int            hold_request = 0;
  int            hold_left = 0;
  bit            idle_en = 1'b1;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic debounce_step(input logic abnormal,
                               inout logic [sfq_pkg::CountW-1:0] cnt, inout logic flg);
    if (abnormal) begin
      if (cnt < confirm_n) cnt = cnt + 1'b1;
      else flg = 1'b1;
    end else if (flg) begin
      if (cnt <= 1) begin
        cnt = '0;
        flg = 1'b0;
      end else begin
        cnt = cnt - 1'b1;
      end
    end else begin
      cnt = '0;
    end
  endtask

  task automatic qualify_beat(input logic [sfq_pkg::ReadingW-1:0] rd,
                              input logic [sfq_pkg::IndexW-1:0] ix,
                              output fault_result_t res);
    logic [sfq_pkg::ChangeW:0] next_chg;
    debounce_step(rd > thr_open, open_cnt, open_flg);
    debounce_step(rd < thr_short, short_cnt, short_flg);
    if (ix != held_idx) begin
      next_chg = {1'b0, chg_cnt} + 1'b1;
      if (next_chg > {1'b0, chg_limit}) begin
        held_idx = ix;
        chg_cnt = '0;
      end else begin
        chg_cnt = next_chg[sfq_pkg::ChangeW-1:0];
      end
    end else begin
      chg_cnt = '0;
    end
    res.open_f  = open_flg;
    res.short_f = short_flg;
    res.idx     = held_idx;
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input logic [sfq_pkg::ReadingW-1:0] rd,
                           input logic [sfq_pkg::IndexW-1:0] ix,
                           input logic chk, input fault_result_t typed);
    fault_result_t pred;
    while (idle_en && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_raw_reading <= rd;
    in_temp_index  <= ix;
    do @(posedge clk); while (in_stall);
    qualify_beat(rd, ix, pred);
    pending_results.push_back(chk ? typed : pred);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    @(negedge clk);
  endtask

  task automatic cfg_set(input sfq_pkg::reg_idx_t sel, input logic [sfq_pkg::DataW-1:0] value);
    logic [sfq_pkg::DataW-1:0] stored;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (sel)
      sfq_pkg::REG_OPEN_THRESHOLD:  thr_open  = value[sfq_pkg::ReadingW-1:0];
      sfq_pkg::REG_SHORT_THRESHOLD: thr_short = value[sfq_pkg::ReadingW-1:0];
      sfq_pkg::REG_CONFIRM_COUNT:   confirm_n = value[sfq_pkg::CountW-1:0];
      sfq_pkg::REG_CHANGE_LIMIT:    chg_limit = value[sfq_pkg::ChangeW-1:0];
      default: ;
    endcase
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (sel)
      sfq_pkg::REG_OPEN_THRESHOLD:  stored = sfq_pkg::DataW'(thr_open);
      sfq_pkg::REG_SHORT_THRESHOLD: stored = sfq_pkg::DataW'(thr_short);
      sfq_pkg::REG_CONFIRM_COUNT:   stored = sfq_pkg::DataW'(confirm_n);
      default:                      stored = sfq_pkg::DataW'(chg_limit);
    endcase
    if (prdata !== stored) begin
      $error("prdata %s: expected %0d, actual %0d", sel.name(), stored, prdata);
      error_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [sfq_pkg::ReadingW-1:0] pick_reading(run_kind_t kind);
    case (kind)
      RUN_OPEN:
        return (thr_open < 12'hFFF)
               ? sfq_pkg::ReadingW'($urandom_range(4095, thr_open + 1))
               : sfq_pkg::ReadingW'($urandom_range(4095, 0));
      RUN_SHORT:
        return (thr_short > 0) ? sfq_pkg::ReadingW'($urandom_range(thr_short - 1, 0))
                               : sfq_pkg::ReadingW'($urandom_range(4095, 0));
      RUN_NORMAL:
        return (thr_short <= thr_open)
               ? sfq_pkg::ReadingW'($urandom_range(thr_open, thr_short))
               : sfq_pkg::ReadingW'($urandom_range(4095, 0));
      default:
        if ($urandom_range(4) == 0) return $urandom_range(1) ? 12'hFFF : 12'h000;
        else return sfq_pkg::ReadingW'($urandom_range(4095, 0));
    endcase
  endfunction

  task automatic run_phase(input int beats, input bit do_hold, input bit do_pause);
    run_kind_t                  kind = RUN_NORMAL;
    int                         run_left = 0;
    int                         pick;
    logic [sfq_pkg::IndexW-1:0] cur_idx = sfq_pkg::IndexW'($urandom_range(255));
    logic [sfq_pkg::IndexW-1:0] ix;
    for (int i = 0; i < beats; i++) begin
      if (run_left == 0) begin
        pick = $urandom_range(9);
        kind = (pick < 3) ? RUN_OPEN : (pick < 5) ? RUN_SHORT : (pick < 8) ? RUN_NORMAL
                                                                          : RUN_NOISE;
        run_left = $urandom_range(confirm_n + 6, 1);
        if ($urandom_range(3) == 0) cur_idx = sfq_pkg::IndexW'($urandom_range(255));
      end
      run_left--;
      ix = (kind == RUN_NOISE || $urandom_range(9) == 0)
           ? sfq_pkg::IndexW'($urandom_range(255)) : cur_idx;
      if (i == beats / 2) begin
        if (do_hold) hold_request = 80;
        if (do_pause) drain_results();
      end
      send_beat(pick_reading(kind), ix, 1'b0, '0);
    end
  endtask

  function automatic stim_row_t mk_beat(input int rd, input int ix, input logic chk,
                                        input fault_result_t typed);
    stim_row_t row;
    row.is_cfg  = 1'b0;
    row.reg_sel = sfq_pkg::REG_OPEN_THRESHOLD;
    row.wdata   = '0;
    row.reading = sfq_pkg::ReadingW'(rd);
    row.index   = sfq_pkg::IndexW'(ix);
    row.chk     = chk;
    row.typed   = typed;
    return row;
  endfunction

  function automatic stim_row_t mk_cfg(input sfq_pkg::reg_idx_t sel, input int value);
    stim_row_t row;
    row = mk_beat(0, 0, 1'b0, '0);
    row.is_cfg  = 1'b1;
    row.reg_sel = sel;
    row.wdata   = sfq_pkg::DataW'(value);
    return row;
  endfunction

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= idle_en && ($urandom_range(99) < 7);
      end
    end
  end

  always @(posedge clk) begin
    fault_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation pending");
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_open_fault !== exp_res.open_f) begin
          $error("open_fault: expected %0d, actual %0d", exp_res.open_f, out_open_fault);
          error_count++;
        end
        if (out_short_fault !== exp_res.short_f) begin
          $error("short_fault: expected %0d, actual %0d", exp_res.short_f, out_short_fault);
          error_count++;
        end
        if (out_stable_index !== exp_res.idx) begin
          $error("stable_index: expected %0d, actual %0d", exp_res.idx, out_stable_index);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_sensor_fault_qualifier_top: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_raw_reading = '0;
    in_temp_index  = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;

    directed_rows.push_back(mk_beat(2048, 0, 1'b1, '{1'b0, 1'b0, 8'd0}));
    directed_rows.push_back(mk_beat(4095, 255, 1'b1, '{1'b0, 1'b0, 8'd0}));
    directed_rows.push_back(mk_beat(0, 255, 1'b1, '{1'b0, 1'b0, 8'd0}));
    directed_rows.push_back(mk_beat(4000, 0, 1'b0, '0));
    directed_rows.push_back(mk_beat(40, 128, 1'b0, '0));
    directed_rows.push_back(mk_cfg(sfq_pkg::REG_CONFIRM_COUNT, 0));
    directed_rows.push_back(mk_beat(4095, 0, 1'b1, '{1'b1, 1'b0, 8'd0}));
    directed_rows.push_back(mk_beat(2048, 0, 1'b1, '{1'b0, 1'b0, 8'd0}));
    directed_rows.push_back(mk_beat(0, 0, 1'b1, '{1'b0, 1'b1, 8'd0}));
    directed_rows.push_back(mk_beat(2048, 0, 1'b1, '{1'b0, 1'b0, 8'd0}));
    directed_rows.push_back(mk_cfg(sfq_pkg::REG_CONFIRM_COUNT, 3));
    repeat (4) directed_rows.push_back(mk_beat(4095, 0, 1'b0, '0));
    directed_rows.push_back(mk_cfg(sfq_pkg::REG_CONFIRM_COUNT, 1));
    directed_rows.push_back(mk_beat(4095, 0, 1'b0, '0));
    repeat (3) directed_rows.push_back(mk_beat(2048, 0, 1'b0, '0));
    directed_rows.push_back(mk_cfg(sfq_pkg::REG_CHANGE_LIMIT, 0));
    directed_rows.push_back(mk_beat(2048, 255, 1'b0, '0));
    directed_rows.push_back(mk_cfg(sfq_pkg::REG_OPEN_THRESHOLD, 4095));
    directed_rows.push_back(mk_beat(4095, 0, 1'b0, '0));
    directed_rows.push_back(mk_cfg(sfq_pkg::REG_SHORT_THRESHOLD, 0));
    directed_rows.push_back(mk_beat(0, 1, 1'b0, '0));
    directed_rows.push_back(mk_cfg(sfq_pkg::REG_CHANGE_LIMIT, 15));
    directed_rows.push_back(mk_cfg(sfq_pkg::REG_OPEN_THRESHOLD, 0));
    directed_rows.push_back(mk_cfg(sfq_pkg::REG_SHORT_THRESHOLD, 4095));
    directed_rows.push_back(mk_beat(1, 170, 1'b0, '0));
    directed_rows.push_back(mk_beat(4094, 85, 1'b0, '0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        drain_results();
        cfg_set(directed_rows[i].reg_sel, directed_rows[i].wdata);
        @(negedge clk);
      end else begin
        send_beat(directed_rows[i].reading, directed_rows[i].index, directed_rows[i].chk,
                  directed_rows[i].typed);
      end
    end

    for (int p = 0; p < PhaseCount; p++) begin
      drain_results();
      case (p)
        0: begin
          cfg_set(sfq_pkg::REG_OPEN_THRESHOLD, 4095);
          cfg_set(sfq_pkg::REG_SHORT_THRESHOLD, 0);
          cfg_set(sfq_pkg::REG_CONFIRM_COUNT, 31);
          cfg_set(sfq_pkg::REG_CHANGE_LIMIT, 15);
        end
        1: begin
          cfg_set(sfq_pkg::REG_OPEN_THRESHOLD, 0);
          cfg_set(sfq_pkg::REG_SHORT_THRESHOLD, 4095);
          cfg_set(sfq_pkg::REG_CONFIRM_COUNT, 0);
          cfg_set(sfq_pkg::REG_CHANGE_LIMIT, 0);
        end
        2: begin
          cfg_set(sfq_pkg::REG_OPEN_THRESHOLD, sfq_pkg::DataW'(sfq_pkg::OpenThresholdRst));
          cfg_set(sfq_pkg::REG_SHORT_THRESHOLD, sfq_pkg::DataW'(sfq_pkg::ShortThresholdRst));
          cfg_set(sfq_pkg::REG_CONFIRM_COUNT, sfq_pkg::DataW'(sfq_pkg::ConfirmCountRst));
          cfg_set(sfq_pkg::REG_CHANGE_LIMIT, sfq_pkg::DataW'(sfq_pkg::ChangeLimitRst));
        end
        default: begin
          cfg_set(sfq_pkg::REG_OPEN_THRESHOLD, $urandom_range(4095, 2000));
          cfg_set(sfq_pkg::REG_SHORT_THRESHOLD, $urandom_range(1500, 0));
          cfg_set(sfq_pkg::REG_CONFIRM_COUNT,
                  (p % 2) ? $urandom_range(31, 1) : $urandom_range(8, 0));
          cfg_set(sfq_pkg::REG_CHANGE_LIMIT, $urandom_range(15, 0));
        end
      endcase
      @(negedge clk);
      idle_en = (p != 7);
      run_phase(PhaseBeats, p == 3 || p == 9, p == 5);
    end

    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_sensor_fault_qualifier_top: PASS");
    end else begin
      $display("tb_sensor_fault_qualifier_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/sfq_pkg.sv
rtl/core/sfq_cfg_regs.sv
rtl/core/sfq_debounce.sv
rtl/core/sfq_index_hold.sv
rtl/core/sensor_fault_qualifier_top.sv
bench/tb_sensor_fault_qualifier_top.sv
